@@ rtl/sli_pkg.sv @@
// Shared types and constants for the sorted list insert and delete block.
package sli_pkg;

	localparam int CAPACITY = 16;
	localparam int COUNT_W  = $clog2(CAPACITY + 1);
	localparam int VALUE_W  = 32;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_DELETE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef struct packed {
		op_t                       op;
		logic signed [VALUE_W-1:0] value;
	} req_word_t;

	typedef struct packed {
		status_t                   status;
		logic [4:0]                stored_count;
		logic signed [VALUE_W-1:0] smallest;
		logic                      list_empty;
	} rsp_word_t;

	typedef struct packed {
		logic load;
		logic commit;
	} dp_cmd_t;

endpackage

@@ rtl/sli_ctrl.sv @@
// Controller state machine for the sorted list: handshakes and datapath commands.
module sli_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output sli_pkg::dp_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE   = 2'b01,
		S_UPDATE = 2'b10
	} state_t;

	state_t state_q;
	state_t state_n;
	logic   rsp_valid_q;
	logic   rsp_free;

	// The result register can take a new word when empty or when its word leaves now.
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_n    = state_q;
		cmd.load   = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_n  = S_UPDATE;
				end
			end
			S_UPDATE: begin
				if (rsp_free) begin
					cmd.commit = 1'b1;
					state_n    = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.commit)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

endmodule

@@ rtl/sli_datapath.sv @@
// Datapath for the sorted list: entry cells, parallel compares, shift and result register.
module sli_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  sli_pkg::dp_cmd_t   cmd,
	input  sli_pkg::req_word_t req,
	output sli_pkg::rsp_word_t rsp
);

	localparam int CAP = sli_pkg::CAPACITY;
	localparam int CW  = sli_pkg::COUNT_W;
	localparam int VW  = sli_pkg::VALUE_W;

	logic signed [VW-1:0] cell_q [CAP];
	logic signed [VW-1:0] cell_n [CAP];
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        count_n;
	sli_pkg::op_t         op_q;
	logic signed [VW-1:0] value_q;
	logic [CAP-1:0]       lt_q;
	logic [CAP-1:0]       eq_q;
	logic [CAP-1:0]       lt_n;
	logic [CAP-1:0]       eq_n;
	logic [CAP-1:0]       eq_low;
	logic [CAP-1:0]       from_match;
	logic [CAP-1:0]       at_pos;
	logic                 full;
	logic                 found;
	sli_pkg::status_t     status_n;
	sli_pkg::rsp_word_t   rsp_q;

	// Every held entry is compared with the incoming value at once.
	always_comb begin
		for (int i = 0; i < CAP; i++) begin
			lt_n[i] = (CW'(i) < count_q) && (cell_q[i] < req.value);
			eq_n[i] = (CW'(i) < count_q) && (cell_q[i] == req.value);
		end
	end

	// The lowest match and every cell above it close the gap by one place.
	assign eq_low     = eq_q & (~eq_q + CAP'(1));
	assign from_match = ~(eq_low - CAP'(1));
	assign full       = (count_q == CW'(CAP));
	assign found      = |eq_q;

	always_comb begin
		at_pos[0] = !lt_q[0];
		for (int i = 1; i < CAP; i++)
			at_pos[i] = !lt_q[i] && lt_q[i-1];
	end

	always_comb begin
		for (int i = 0; i < CAP; i++)
			cell_n[i] = cell_q[i];
		count_n  = count_q;
		status_n = sli_pkg::ST_DONE;
		case (op_q)
			sli_pkg::OP_INSERT: begin
				if (full) begin
					status_n = sli_pkg::ST_FULL;
				end else begin
					count_n = count_q + CW'(1);
					for (int i = 0; i < CAP; i++) begin
						if (at_pos[i])
							cell_n[i] = value_q;
						else if (!lt_q[i] && i > 0)
							cell_n[i] = cell_q[(i > 0) ? i - 1 : 0];
					end
				end
			end
			sli_pkg::OP_DELETE: begin
				if (!found) begin
					status_n = sli_pkg::ST_NOT_FOUND;
				end else begin
					count_n = count_q - CW'(1);
					for (int i = 0; i < CAP - 1; i++) begin
						if (from_match[i])
							cell_n[i] = cell_q[i+1];
					end
				end
			end
			default: status_n = sli_pkg::ST_DONE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= req.op;
			value_q <= req.value;
			lt_q    <= lt_n;
			eq_q    <= eq_n;
		end
		if (cmd.commit) begin
			for (int i = 0; i < CAP; i++)
				cell_q[i] <= cell_n[i];
			rsp_q.status       <= status_n;
			rsp_q.stored_count <= 5'(count_n);
			rsp_q.smallest     <= (count_n == '0) ? '0 : cell_n[0];
			rsp_q.list_empty   <= (count_n == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			count_q <= '0;
		else if (cmd.commit)
			count_q <= count_n;
	end

	assign rsp = rsp_q;

endmodule

@@ rtl/sorted_list_insert_delete.sv @@
// Top level of the sorted list block: controller, datapath and checks.
// The block holds up to sixteen signed 32-bit entries in ascending order and answers
// every request word with one response word: a status, the entry count, the smallest
// entry (zero when empty) and an empty flag. An insert into a full list and a delete
// with no equal entry leave the list unchanged and say so in the status. An accepted
// request has all entries compared with its value in parallel and registered; in the
// update state the cells shift and the response register loads once it is free. No new
// request is taken until that update is done; the response register lets the next
// request in while the previous word still waits.
module sorted_list_insert_delete (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  sli_pkg::req_word_t req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output sli_pkg::rsp_word_t rsp
);

	sli_pkg::dp_cmd_t cmd;

	sli_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	sli_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

	// An accepted word keeps the request side closed for its update cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request accepted back to back");

	// A new response appears only out of the update cycle.
	a_rsp_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("response without an update");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.list_empty == (rsp.stored_count == 5'd0)))
		else $error("empty flag disagrees with count");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == sli_pkg::ST_FULL)
			|-> (rsp.stored_count == 5'(sli_pkg::CAPACITY)))
		else $error("full status with room left");

endmodule

@@ verif/sli_checker.sv @@
// Checker for the sorted list block: tracks the list contents and compares every response word.
module sli_checker
	import sli_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      req_stall,
	input  req_word_t req,
	input  logic      rsp_valid,
	input  logic      rsp_stall,
	input  rsp_word_t rsp,
	output int        fail_count,
	output int        pending
);

	logic signed [VALUE_W-1:0] held[CAPACITY];
	int                        held_n;
	rsp_word_t                 expected_words[$];

	// Applies one request word to the tracked list and returns the response it must produce.
	function automatic rsp_word_t apply_request(input req_word_t w);
		rsp_word_t r;
		int        pos;
		r = '0;
		r.status = ST_DONE;
		pos = 0;
		if (w.op == OP_INSERT) begin
			if (held_n >= CAPACITY) begin
				r.status = ST_FULL;
			end else begin
				while (pos < held_n && held[pos] < w.value) pos++;
				for (int i = held_n; i > pos; i--) held[i] = held[i-1];
				held[pos] = w.value;
				held_n++;
			end
		end else begin
			while (pos < held_n && held[pos] != w.value) pos++;
			if (pos >= held_n) begin
				r.status = ST_NOT_FOUND;
			end else begin
				for (int i = pos; i + 1 < held_n; i++) held[i] = held[i+1];
				held_n--;
			end
		end
		r.stored_count = 5'(held_n);
		r.list_empty   = (held_n == 0);
		r.smallest     = r.list_empty ? '0 : held[0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_word_t want;
		if (!arst_n) begin
			held_n = 0;
			expected_words.delete();
			fail_count = 0;
		end else begin
			// The response side is checked before this edge's request is applied, so a
			// word accepted at the same edge never meets its own expectation.
			if (rsp_valid && !rsp_stall) begin
				if (expected_words.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected response word: status %0d count %0d",
							rsp.status, rsp.stored_count,
							" smallest %0d empty %0b", rsp.smallest, rsp.list_empty);
				end else begin
					want = expected_words.pop_front();
					if (rsp.status != want.status || rsp.stored_count != want.stored_count ||
					    rsp.smallest != want.smallest || rsp.list_empty != want.list_empty) begin
						fail_count++;
						if (fail_count <= 10)
							$display("response mismatch: expected status %0d count %0d",
								want.status, want.stored_count,
								" smallest %0d empty %0b,", want.smallest, want.list_empty,
								" got status %0d count %0d", rsp.status, rsp.stored_count,
								" smallest %0d empty %0b", rsp.smallest, rsp.list_empty);
					end
				end
			end
			if (req_valid && !req_stall)
				expected_words.push_back(apply_request(req));
		end
		pending = expected_words.size();
	end

endmodule

@@ verif/tb_top.sv @@
// Testbench top for the sorted list block: stimulus, handshake pacing and the verdict.
module tb_top;
	import sli_pkg::*;

	localparam int ITEMS_PER_PHASE = 210;
	localparam int CYCLE_LIMIT     = 300000;
	localparam int HOLD_CYCLES     = 300;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_word_t req       = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_word_t rsp;
	int        fail_count;
	int        pending;

	int tx_idle     = 20;
	int rx_idle     = 87;
	bit hold_wanted = 1'b0;
	bit hold_used   = 1'b0;
	int hold_left   = 0;
	int cycles      = 0;

	logic signed [VALUE_W-1:0] pool[6];

	sorted_list_insert_delete i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	sli_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always #6 clk = ~clk;

	// Response side: random stall, plus one long hold-off that lets the list back up.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_wanted && !hold_used) begin
			rsp_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_used <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(1, 100) <= rx_idle);
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	// Offers one word, after a random idle gap, and returns at the edge that accepts it.
	task automatic send_word(input op_t o, input logic signed [VALUE_W-1:0] v);
		while ($urandom_range(1, 100) <= tx_idle) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= '{op: o, value: v};
		do @(posedge clk); while (req_stall);
	endtask

	task automatic refresh_pool();
		for (int i = 0; i < 6; i++) begin
			case ($urandom_range(0, 5))
				0: pool[i] = 32'sh8000_0000;
				1: pool[i] = 32'sh7fff_ffff;
				2: pool[i] = 32'($signed($urandom_range(0, 6)) - 3);
				default: pool[i] = $urandom();
			endcase
		end
	endtask

	initial begin
		int ins_pct;
		op_t o;
		logic signed [VALUE_W-1:0] v;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty list, extremes, duplicates, misses, a full list.
		send_word(OP_DELETE, 32'sd0);
		send_word(OP_INSERT, 32'sh7fff_ffff);
		send_word(OP_INSERT, 32'sh8000_0000);
		send_word(OP_INSERT, 32'sd0);
		send_word(OP_INSERT, -32'sd1);
		send_word(OP_INSERT, 32'sd0);
		send_word(OP_DELETE, 32'sd5);
		send_word(OP_DELETE, 32'sd0);
		send_word(OP_DELETE, 32'sh8000_0000);
		for (int i = 0; i < 13; i++) send_word(OP_INSERT, $urandom());
		send_word(OP_INSERT, 32'sd77);
		send_word(OP_DELETE, 32'sh7fff_ffff);
		send_word(OP_INSERT, 32'sh8000_0000);

		for (int ph = 0; ph < 3; ph++) begin
			tx_idle = (ph == 0) ? 20 : (ph == 1) ? 87 : 0;
			rx_idle = (ph == 0) ? 87 : (ph == 1) ? 20 : 0;
			ins_pct = 50;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// Bias the insert rate in stretches so the list swings between empty and full.
				if (n % 35 == 0) begin
					refresh_pool();
					case ($urandom_range(0, 2))
						0: ins_pct = 30;
						1: ins_pct = 50;
						default: ins_pct = 75;
					endcase
				end
				if (ph == 2 && n == 20) hold_wanted = 1'b1;
				o = ($urandom_range(1, 100) <= ins_pct) ? OP_INSERT : OP_DELETE;
				v = ($urandom_range(1, 10) <= 7) ? pool[$urandom_range(0, 5)] : $urandom();
				send_word(o, v);
			end
		end
		req_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
